FILE: hdl/hrd_pkg.sv
// hrd_pkg: shared types and constants for the HTTP response deframer.
// Holds the payload structs, status codes, phase codes and the header table.
// No dependencies.
package hrd_pkg;

  localparam int HdrTableLen = 157;

  localparam logic [8*HdrTableLen-1:0] HDR_STR =
    {"HTTP/1.1 200 OK\r\n",
     "Expires: Thu, 01 Jan 1970 00:00:00 GMT\r\n",
     "Cache-Control: no-store\r\n",
     "Connection: close\r\n",
     "Content-Type: application/octet-stream\r\n",
     "Content-Length: "};

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_0  = 8'd48;
  localparam logic [7:0] CHAR_9  = 8'd57;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_DIGITS   = 3'd1;
  localparam logic [2:0] PH_TERM     = 3'd2;
  localparam logic [2:0] PH_BODY     = 3'd3;
  localparam logic [2:0] PH_REJECT   = 3'd4;
  localparam logic [2:0] PH_OVERLONG = 3'd5;

  localparam logic [1:0] ST_PENDING    = 2'd0;
  localparam logic [1:0] ST_GOOD       = 2'd1;
  localparam logic [1:0] ST_BAD        = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } hrd_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_is_body;
    logic [1:0]  out_status;
    logic [63:0] out_length;
    logic        out_last;
  } hrd_out_t;

  // expected header byte; positions past the table expect zero
  function automatic logic [7:0] hdr_byte(input logic [7:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (int'(idx) < HdrTableLen) begin
      b = HDR_STR[8*(HdrTableLen-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

  // CR LF CR LF
  function automatic logic [7:0] term_byte(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage

FILE: hdl/hrd_stream_if.sv
// hrd_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; used with the structs from hrd_pkg.
interface hrd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/hrd_core.sv
// hrd_core: message parse state and the per-byte step logic.
// Depends on hrd_pkg; the result is combinational, state updates on step.
module hrd_core
  import hrd_pkg::*;
#(
  parameter int HEADER_LEN = 157,
  parameter int MAX_DIGITS = 20
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  hrd_in_t  item,
  output hrd_out_t result
);

  logic [2:0]  phase, phase_next;
  logic [7:0]  header_index, header_index_next;
  logic        bad_seen, bad_seen_next;
  logic [63:0] content_length, content_length_next;
  logic [4:0]  digit_count, digit_count_next;
  logic [2:0]  terminator_index, terminator_index_next;
  logic [63:0] body_count, body_count_next;

  logic [7:0]  b;
  logic        is_digit;
  logic        term_bad;
  logic [2:0]  term_index_inc;
  logic [8:0]  header_index_inc;
  logic        is_body;
  logic [1:0]  status;

  always_comb begin
    b                     = item.in_byte;
    is_digit              = (b >= CHAR_0) && (b <= CHAR_9);
    phase_next            = phase;
    header_index_next     = header_index;
    bad_seen_next         = bad_seen;
    content_length_next   = content_length;
    digit_count_next      = digit_count;
    terminator_index_next = terminator_index;
    body_count_next       = body_count;
    is_body               = 1'b0;
    status                = ST_PENDING;

    header_index_inc = {1'b0, header_index} + 9'd1;
    term_index_inc   = terminator_index + 3'd1;
    term_bad         = b != term_byte(terminator_index[1:0]);

    unique case (phase)
      PH_HEADER: begin
        bad_seen_next     = bad_seen | (b != hdr_byte(header_index));
        header_index_next = header_index_inc[7:0];
        if (header_index_inc >= 9'(HEADER_LEN)) begin
          phase_next = bad_seen_next ? PH_REJECT : PH_DIGITS;
        end
      end
      PH_DIGITS, PH_TERM: begin
        if (phase == PH_DIGITS && is_digit) begin
          if (digit_count >= 5'(MAX_DIGITS)) begin
            phase_next = PH_OVERLONG;
          end else begin
            content_length_next = (content_length << 3) + (content_length << 1)
                                  + {60'd0, b[3:0]};
            digit_count_next    = digit_count + 5'd1;
          end
        end else begin
          bad_seen_next         = bad_seen | term_bad;
          terminator_index_next = term_index_inc;
          if (term_index_inc >= 3'd4) begin
            phase_next = bad_seen_next ? PH_REJECT : PH_BODY;
          end else begin
            phase_next = PH_TERM;
          end
        end
      end
      PH_BODY: begin
        is_body = body_count < content_length;
        if (body_count != {64{1'b1}}) begin
          body_count_next = body_count + 64'd1;
        end
      end
      default: begin
      end
    endcase

    // length is final once the body phase is reached
    if (item.in_last) begin
      unique case (phase_next)
        PH_BODY: begin
          if (body_count_next < content_length) begin
            status = ST_INCOMPLETE;
          end else if (body_count_next == content_length) begin
            status = ST_GOOD;
          end else begin
            status = ST_BAD;
          end
        end
        PH_HEADER, PH_DIGITS, PH_TERM, PH_OVERLONG: status = ST_INCOMPLETE;
        default: status = ST_BAD;
      endcase
    end

    result.out_byte    = is_body ? b : 8'd0;
    result.out_is_body = is_body;
    result.out_status  = status;
    result.out_length  = content_length_next;
    result.out_last    = item.in_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.in_last)) begin
      phase            <= PH_HEADER;
      header_index     <= 8'd0;
      bad_seen         <= 1'b0;
      content_length   <= 64'd0;
      digit_count      <= 5'd0;
      terminator_index <= 3'd0;
      body_count       <= 64'd0;
    end else if (step) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      bad_seen         <= bad_seen_next;
      content_length   <= content_length_next;
      digit_count      <= digit_count_next;
      terminator_index <= terminator_index_next;
      body_count       <= body_count_next;
    end
  end

endmodule

FILE: hdl/http_response_deframer_unit.sv
// http_response_deframer_unit: top level; input register, hrd_core, result register.
// Throughput: one byte per cycle while tx.ready is high; the input register frees as the result register loads.
// Reset: synchronous rst clears both valid flags and the parse state to header match.
// Depends on hrd_pkg, hrd_stream_if and hrd_core.
module http_response_deframer_unit
  import hrd_pkg::*;
#(
  parameter int HEADER_LEN = 157,
  parameter int MAX_DIGITS = 20
) (
  input logic         clk,
  input logic         rst,
  hrd_stream_if.sink   rx,
  hrd_stream_if.source tx
);

  logic     in_valid;
  hrd_in_t  in_item;
  logic     out_valid;
  hrd_out_t out_item;
  hrd_out_t core_result;
  logic     advance;

  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;
  assign tx.valid = out_valid;
  assign tx.data  = out_item;

  hrd_core #(
    .HEADER_LEN(HEADER_LEN),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_item <= rx.data;
    end
    if (advance) begin
      out_item <= core_result;
    end
  end

endmodule

FILE: verif/tb_http_response_deframer_unit.sv
// tb_http_response_deframer_unit: self-checking testbench for the HTTP response deframer.
// Drives whole messages byte by byte, predicts every result and compares field by field.
// Depends on hrd_pkg, hrd_stream_if and http_response_deframer_unit.
module tb_http_response_deframer_unit;
  import hrd_pkg::*;

  localparam int HeaderLen = 157;
  localparam int MaxDigits = 20;

  logic clk = 1'b0;
  logic rst;

  hrd_stream_if #(.payload_t(hrd_in_t)) rx_if ();
  hrd_stream_if #(.payload_t(hrd_out_t)) tx_if ();

  http_response_deframer_unit #(
    .HEADER_LEN(HeaderLen),
    .MAX_DIGITS(MaxDigits)
  ) uut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .tx(tx_if)
  );

  always #5 clk = ~clk;

  string      header_text;
  logic [7:0] term_seq [4] = '{8'd13, 8'd10, 8'd13, 8'd10};

  // predicted parser state
  logic [2:0]  pr_phase;
  logic [7:0]  pr_hdr_idx;
  logic        pr_bad;
  logic [63:0] pr_len;
  logic [4:0]  pr_digits;
  logic [2:0]  pr_term_idx;
  logic [63:0] pr_body_cnt;

  hrd_out_t   expected_results [$];
  logic [7:0] msg_bytes [$];
  int         mismatch_count = 0;
  int         hold_len = 0;
  bit         idle_on = 1'b1;

  function automatic void deframe_clear();
    pr_phase    = PH_HEADER;
    pr_hdr_idx  = '0;
    pr_bad      = 1'b0;
    pr_len      = '0;
    pr_digits   = '0;
    pr_term_idx = '0;
    pr_body_cnt = '0;
  endfunction

  function automatic void term_advance(input logic [7:0] b);
    if (b != term_seq[pr_term_idx[1:0]]) pr_bad = 1'b1;
    pr_term_idx = pr_term_idx + 3'd1;
    if (pr_term_idx >= 3'd4) begin
      pr_phase = pr_bad ? PH_REJECT : PH_BODY;
    end else begin
      pr_phase = PH_TERM;
    end
  endfunction

  function automatic hrd_out_t deframe_predict(input logic [7:0] b, input logic last);
    hrd_out_t r;
    r = '0;
    case (pr_phase)
      PH_HEADER: begin
        if (b != 8'(header_text[pr_hdr_idx])) pr_bad = 1'b1;
        pr_hdr_idx = pr_hdr_idx + 8'd1;
        if (int'(pr_hdr_idx) >= HeaderLen) pr_phase = pr_bad ? PH_REJECT : PH_DIGITS;
      end
      PH_DIGITS: begin
        if (b >= CHAR_0 && b <= CHAR_9) begin
          if (int'(pr_digits) >= MaxDigits) begin
            pr_phase = PH_OVERLONG;
          end else begin
            pr_len    = pr_len * 64'd10 + {56'd0, b - CHAR_0};
            pr_digits = pr_digits + 5'd1;
          end
        end else begin
          term_advance(b);
        end
      end
      PH_TERM: term_advance(b);
      PH_BODY: begin
        if (pr_body_cnt < pr_len) begin
          r.out_is_body = 1'b1;
          r.out_byte    = b;
        end
        if (pr_body_cnt != '1) pr_body_cnt = pr_body_cnt + 64'd1;
      end
      default: ;
    endcase
    r.out_status = ST_PENDING;
    if (last) begin
      if (pr_phase == PH_BODY) begin
        if (pr_body_cnt < pr_len) r.out_status = ST_INCOMPLETE;
        else if (pr_body_cnt == pr_len) r.out_status = ST_GOOD;
        else r.out_status = ST_BAD;
      end else if (pr_phase == PH_HEADER || pr_phase == PH_DIGITS ||
                   pr_phase == PH_TERM || pr_phase == PH_OVERLONG) begin
        r.out_status = ST_INCOMPLETE;
      end else begin
        r.out_status = ST_BAD;
      end
    end
    r.out_length = pr_len;
    r.out_last   = last;
    if (last) deframe_clear();
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    hrd_out_t want;
    hrd_out_t got;
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        expected_results.push_back(deframe_predict(rx_if.data.in_byte, rx_if.data.in_last));
      end
      if (tx_if.valid && tx_if.ready) begin
        got = tx_if.data;
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            mismatch_count++;
          end
          if (got.out_is_body !== want.out_is_body) begin
            $error("out_is_body: expected %0d, actual %0d", want.out_is_body, got.out_is_body);
            mismatch_count++;
          end
          if (got.out_status !== want.out_status) begin
            $error("out_status: expected %0d, actual %0d", want.out_status, got.out_status);
            mismatch_count++;
          end
          if (got.out_length !== want.out_length) begin
            $error("out_length: expected %0d, actual %0d", want.out_length, got.out_length);
            mismatch_count++;
          end
          if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0d, actual %0d", want.out_last, got.out_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // result side: long hold on request, random stall bursts, else ready
  initial begin : result_sink
    forever begin
      if (hold_len > 0) begin
        tx_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        tx_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        tx_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    hrd_in_t item;
    item.in_byte = b;
    item.in_last = last;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.data  <= item;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    msg_bytes.delete();
  endtask

  task automatic push_header();
    for (int i = 0; i < HeaderLen; i++) msg_bytes.push_back(8'(header_text[i]));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(8'(s[i]));
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_digit_run(input int n);
    for (int i = 0; i < n; i++) msg_bytes.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_wellformed();
    int v;
    int body_len;
    push_header();
    if ($urandom_range(0, 7) == 0) begin
      push_digit_run($urandom_range(15, MaxDigits));
      body_len = $urandom_range(0, 6);
    end else begin
      v = $urandom_range(0, 40);
      push_text($sformatf("%0d", v));
      case ($urandom_range(0, 5))
        0: body_len = (v > 0) ? v - 1 : 0;
        1: body_len = v + 1;
        default: body_len = v;
      endcase
    end
    push_text("\r\n\r\n");
    push_noise(body_len);
  endtask

  task automatic test_good_messages();
    push_header(); push_text("0\r\n\r\n"); send_message();
    push_header(); push_text("\r\n\r\n"); send_message();
    push_header(); push_text("5\r\n\r\n");
    msg_bytes.push_back(8'h00); msg_bytes.push_back(8'hff); msg_bytes.push_back(8'h55);
    msg_bytes.push_back(8'haa); msg_bytes.push_back(8'h7f);
    send_message();
    push_header(); push_text("007\r\n\r\n"); push_noise(7); send_message();
  endtask

  task automatic test_body_length();
    push_header(); push_text("3\r\n\r\n"); push_noise(1); send_message();
    push_header(); push_text("2\r\n\r\n"); push_noise(4); send_message();
  endtask

  task automatic test_truncation();
    push_text("H"); send_message();
    msg_bytes.push_back(8'hff); send_message();
    push_header();
    msg_bytes[3] = 8'h00;
    while (msg_bytes.size() > 100) msg_bytes.delete(msg_bytes.size() - 1);
    send_message();
    push_header(); send_message();
    push_header(); push_text("12"); send_message();
    push_header(); push_text("4\r\n"); send_message();
    push_header(); push_text("4\r\r"); send_message();
  endtask

  task automatic test_mismatch();
    push_header(); msg_bytes[0] = 8'h00; push_text("1\r\n\r\nX"); send_message();
    push_header(); msg_bytes[HeaderLen - 1] = 8'hff; send_message();
    push_header(); push_text("9\n\r\n\r"); push_noise(9); send_message();
    push_header(); push_text("1A\r\n\rZ"); send_message();
  endtask

  task automatic test_digit_limits();
    push_header(); push_text("18446744073709551615\r\n\r\n"); push_noise(2); send_message();
    push_header(); push_text("99999999999999999999\r\n\r\n"); push_noise(1); send_message();
    push_header(); push_text("18446744073709551616\r\n\r\n"); send_message();
    push_header(); push_text("123456789012345678901\r\n\r\n"); push_noise(3); send_message();
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    push_header(); push_text("30\r\n\r\n"); push_noise(30); send_message();
  endtask

  task automatic test_random_traffic();
    int sent;
    int pos;
    sent = 0;
    while (sent < 1200) begin
      idle_on = (sent < 900);
      case ($urandom_range(0, 9))
        6: begin
          push_wellformed();
          pos = $urandom_range(1, msg_bytes.size() - 1);
          while (msg_bytes.size() > pos) msg_bytes.delete(msg_bytes.size() - 1);
        end
        7: begin
          push_wellformed();
          pos = $urandom_range(0, msg_bytes.size() - 1);
          msg_bytes[pos] = msg_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
        8: push_noise($urandom_range(1, 20));
        9: begin
          push_header();
          push_digit_run($urandom_range(MaxDigits + 1, MaxDigits + 4));
          push_text("\r\n\r\n");
          push_noise(2);
        end
        default: push_wellformed();
      endcase
      sent += msg_bytes.size();
      send_message();
    end
  endtask

  initial begin : main
    int waited;
    header_text = {"HTTP/1.1 200 OK\r\n",
                   "Expires: Thu, 01 Jan 1970 00:00:00 GMT\r\n",
                   "Cache-Control: no-store\r\n",
                   "Connection: close\r\n",
                   "Content-Type: application/octet-stream\r\n",
                   "Content-Length: "};
    deframe_clear();
    rst         <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_good_messages();
    test_body_length();
    test_truncation();
    test_mismatch();
    test_digit_limits();
    test_backpressure();
    test_random_traffic();
    rx_if.valid <= 1'b0;

    waited = 0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
    end
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
